// ===== rtl/core/rsch_pkg.sv =====
// Package for the ray segment closest hit block: widths, default parameters, commands.
// No dependencies.
package rsch_pkg;

    localparam int COORD_W = 24;
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int CNT_W = 7;
    localparam int IDX_W = 6;
    localparam int MAX_WALLS_DEF = 64;
    localparam int T_FRAC_BITS_DEF = 16;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_CAST = 1'b1;

endpackage

// ===== rtl/core/rsch_if.sv =====
// Valid/ready channel interface carrying a payload of type PAYLOAD_T.
// Depends on nothing.
interface rsch_if #(parameter type PAYLOAD_T = logic) (input logic clk);
    logic     valid;
    logic     ready;
    PAYLOAD_T data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/ray_segment_closest_hit.sv =====
// Ray segment closest hit: wall table, cast sequencer with one shared multiplier.
// Uses rsch_pkg, rsch_if, rsch_divider.
//
// Usage: in_ch carries items {cmd, wall_index, start/end x/y}. cmd load writes
// one wall into the internal table and gives no result. cmd cast tests the ray
// against walls 0 .. min(wall_count, MAX_WALLS)-1 and sends one item on out_ch
// {hit, hit_x, hit_y, hit_t}.
// Per wall the sequencer steps through the read, latch, multiply (six products),
// check and advance states; a candidate hit adds the divider and, when it is
// closer, the x and y scale states. With no walls the cast goes straight from
// idle to the output state. in_ch.ready returns in the cycle after the result
// is accepted. The multiplier (25x25) is reused for every product; the divider
// is one bit a cycle. When the receiver stalls the result holds.
// Reset clears the sequencer and wall_count; the wall table is not cleared and
// unwritten entries must not be cast against. The user must write wall_count
// through cfg_we/cfg_data only while idle; the block itself does not enforce it.
module ray_segment_closest_hit
    import rsch_pkg::*;
#(
    parameter int MAX_WALLS   = MAX_WALLS_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [CNT_W-1:0] cfg_data,
    rsch_if.sink          in_ch,
    rsch_if.source        out_ch
);
    localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
    localparam int WC_W = $clog2(MAX_WALLS + 1);
    localparam int T_W = T_FRAC_BITS + 1;
    localparam int LOAD_LIM = (MAX_WALLS < (1 << IDX_W)) ? MAX_WALLS : (1 << IDX_W);
    localparam int CNT_LIM = (MAX_WALLS < (1 << CNT_W) - 1) ? MAX_WALLS : (1 << CNT_W) - 1;

    localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_LAT = 4'd2, S_MUL = 4'd3,
                           S_CHK = 4'd4, S_DIV = 4'd5, S_SCX = 4'd6, S_SCY = 4'd7,
                           S_NEXT = 4'd8, S_OUT = 4'd9;

    logic [4*COORD_W-1:0] mem [MAX_WALLS];
    logic [4*COORD_W-1:0] rd_reg;

    logic [3:0]       st_reg;
    logic [CNT_W-1:0] wc_reg;
    logic [WC_W-1:0]  idx_reg, cnt_reg;
    logic [2:0]       ph_reg;

    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic signed [DIFF_W-1:0]  rx_reg, ry_reg, sx_reg, sy_reg, qx_reg, qy_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [CROSS_W-1:0] d_reg, tn_reg, un_reg;
    logic                      found_reg, ov_reg;
    logic [T_W-1:0]            bt_reg, tq_reg;
    logic signed [COORD_W-1:0] bx_reg, by_reg;

    logic signed [DIFF_W-1:0]  ma, mb;
    logic signed [PROD_W-1:0]  mp;
    logic signed [CROSS_W-1:0] dabs, tabs, uabs;
    logic                      div_start, div_done;
    logic [T_W-1:0]            div_q;
    logic signed [DIFF_W+T_W:0] sprod;
    logic signed [COORD_W-1:0] scaled;

    logic [CNT_W-1:0] wc_lim;
    assign wc_lim = (wc_reg > CNT_W'(CNT_LIM)) ? CNT_W'(CNT_LIM) : wc_reg;

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (ph_reg)
            3'd0: begin ma = rx_reg; mb = sy_reg; end
            3'd1: begin ma = ry_reg; mb = sx_reg; end
            3'd2: begin ma = qx_reg; mb = sy_reg; end
            3'd3: begin ma = qy_reg; mb = sx_reg; end
            3'd4: begin ma = qx_reg; mb = ry_reg; end
            3'd5: begin ma = qy_reg; mb = rx_reg; end
            default: begin ma = '0; mb = '0; end
        endcase
    end
    assign mp = ma * mb;

    assign dabs = d_reg[CROSS_W-1] ? -d_reg : d_reg;
    assign tabs = d_reg[CROSS_W-1] ? -tn_reg : tn_reg;
    assign uabs = d_reg[CROSS_W-1] ? -un_reg : un_reg;

    rsch_divider #(.T_FRAC_BITS(T_FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (tabs),
        .den   (dabs),
        .done  (div_done),
        .quo   (div_q)
    );

    // floor(a*t / 2^F): arithmetic shift of the signed product floors toward -inf
    assign sprod  = (st_reg == S_SCX ? rx_reg : ry_reg) * $signed({1'b0, tq_reg});
    assign scaled = COORD_W'(sprod >>> T_FRAC_BITS);

    assign div_start = (st_reg == S_CHK) && (d_reg != '0) && !tabs[CROSS_W-1]
                       && (tabs <= dabs) && !uabs[CROSS_W-1] && (uabs <= dabs);

    assign in_ch.ready = (st_reg == S_IDLE);
    assign out_ch.valid = (st_reg == S_OUT);
    assign out_ch.data.hit = found_reg;
    assign out_ch.data.hit_x = bx_reg;
    assign out_ch.data.hit_y = by_reg;
    assign out_ch.data.hit_t = found_reg ? bt_reg : '0;

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready && in_ch.data.cmd == CMD_LOAD
            && {1'b0, in_ch.data.wall_index} < (IDX_W+1)'(LOAD_LIM))
        begin
            mem[AW'(in_ch.data.wall_index)] <= {in_ch.data.start_x, in_ch.data.start_y,
                                                in_ch.data.end_x, in_ch.data.end_y};
        end
        rd_reg <= mem[AW'(idx_reg)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            wc_reg <= '0;
            idx_reg <= '0;
            cnt_reg <= '0;
            ph_reg <= '0;
            found_reg <= 1'b0;
            px_reg <= '0;
            py_reg <= '0;
            rx_reg <= '0;
            ry_reg <= '0;
            sx_reg <= '0;
            sy_reg <= '0;
            qx_reg <= '0;
            qy_reg <= '0;
            prod_reg <= '0;
            d_reg <= '0;
            tn_reg <= '0;
            un_reg <= '0;
            ov_reg <= 1'b0;
            bt_reg <= '0;
            tq_reg <= '0;
            bx_reg <= '0;
            by_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                wc_reg <= cfg_data;
            end
            case (st_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.data.cmd == CMD_CAST)
                    begin
                        px_reg <= in_ch.data.start_x;
                        py_reg <= in_ch.data.start_y;
                        rx_reg <= DIFF_W'(in_ch.data.end_x) - DIFF_W'(in_ch.data.start_x);
                        ry_reg <= DIFF_W'(in_ch.data.end_y) - DIFF_W'(in_ch.data.start_y);
                        bx_reg <= in_ch.data.end_x;
                        by_reg <= in_ch.data.end_y;
                        found_reg <= 1'b0;
                        bt_reg <= '0;
                        idx_reg <= '0;
                        cnt_reg <= WC_W'(wc_lim);
                        st_reg <= (wc_lim == '0) ? S_OUT : S_RD;
                    end
                end
                S_RD: st_reg <= S_LAT;
                S_LAT:
                begin
                    sx_reg <= DIFF_W'($signed(rd_reg[2*COORD_W-1:COORD_W]))
                            - DIFF_W'($signed(rd_reg[4*COORD_W-1:3*COORD_W]));
                    sy_reg <= DIFF_W'($signed(rd_reg[COORD_W-1:0]))
                            - DIFF_W'($signed(rd_reg[3*COORD_W-1:2*COORD_W]));
                    qx_reg <= DIFF_W'($signed(rd_reg[4*COORD_W-1:3*COORD_W])) - DIFF_W'(px_reg);
                    qy_reg <= DIFF_W'($signed(rd_reg[3*COORD_W-1:2*COORD_W])) - DIFF_W'(py_reg);
                    ph_reg <= '0;
                    st_reg <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg <= mp;
                    ph_reg <= ph_reg + 1'b1;
                    case (ph_reg)
                        3'd1: d_reg <= CROSS_W'(prod_reg) - CROSS_W'(mp);
                        3'd3: tn_reg <= CROSS_W'(prod_reg) - CROSS_W'(mp);
                        3'd5:
                        begin
                            un_reg <= CROSS_W'(prod_reg) - CROSS_W'(mp);
                            st_reg <= S_CHK;
                        end
                        default: ;
                    endcase
                end
                S_CHK: st_reg <= div_start ? S_DIV : S_NEXT;
                S_DIV:
                begin
                    if (div_done)
                    begin
                        tq_reg <= div_q;
                        ov_reg <= !found_reg || (div_q < bt_reg);
                        st_reg <= (!found_reg || (div_q < bt_reg)) ? S_SCX : S_NEXT;
                    end
                end
                S_SCX:
                begin
                    bx_reg <= px_reg + scaled;
                    st_reg <= S_SCY;
                end
                S_SCY:
                begin
                    by_reg <= py_reg + scaled;
                    bt_reg <= tq_reg;
                    found_reg <= ov_reg;
                    st_reg <= S_NEXT;
                end
                S_NEXT:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    st_reg <= (idx_reg + 1'b1 == cnt_reg) ? S_OUT : S_RD;
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                    begin
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/core/rsch_divider.sv =====
// Restoring fractional divider: floor(n * 2^FRAC / d) for 0 <= n <= d, one bit per cycle.
// Uses rsch_pkg.
module rsch_divider
    import rsch_pkg::*;
#(
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [CROSS_W-1:0]       num,
    input  logic [CROSS_W-1:0]       den,
    output logic                     done,
    output logic [T_FRAC_BITS:0]     quo
);
    localparam int STEP_W = $clog2(T_FRAC_BITS + 1);

    logic [CROSS_W:0]       rem_reg, rem_next;
    logic [CROSS_W-1:0]     den_reg, den_next;
    logic [T_FRAC_BITS:0]   quo_reg, quo_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CROSS_W:0]       shifted;

    assign shifted = {rem_reg[CROSS_W-1:0], 1'b0};

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            den_next  = den;
            rem_next  = {1'b0, num};
            quo_next  = '0;
            step_next = '0;
            if (num >= den)
            begin
                quo_next  = {1'b1, {T_FRAC_BITS{1'b0}}};
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = shifted - {1'b0, den_reg};
                quo_next = {quo_reg[T_FRAC_BITS-1:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[T_FRAC_BITS-1:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(T_FRAC_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

// ===== dv/ray_segment_closest_hit_tb_pkg.sv =====
// Testbench package: item types of the two channels and the hit scoreboard.
// Depends on rsch_pkg.
`timescale 1ns / 1ps
package ray_segment_closest_hit_tb_pkg;
    import rsch_pkg::*;

    typedef struct packed {
        logic                      cmd;
        logic [IDX_W-1:0]          wall_index;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } ray_item_t;

    typedef struct packed {
        logic                         hit;
        logic signed [COORD_W-1:0]    hit_x;
        logic signed [COORD_W-1:0]    hit_y;
        logic [T_FRAC_BITS_DEF:0]     hit_t;
    } hit_item_t;

    class hit_scoreboard;
        ray_item_t   walls [MAX_WALLS_DEF];
        int          wall_count;
        hit_item_t   expected_hits [$];
        int          errors;

        function new();
            wall_count = 0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        // floor(n * 2^T / d) for 0 <= n <= d
        function longint t_quantize(longint n, longint d);
            longint q;
            longint rem;
            q = 0;
            rem = n;
            if (n >= d)
                return longint'(1) << T_FRAC_BITS_DEF;
            for (int i = 0; i < T_FRAC_BITS_DEF; i++)
            begin
                rem = rem <<< 1;
                q = q <<< 1;
                if (rem >= d)
                begin
                    rem -= d;
                    q |= 1;
                end
            end
            return q;
        endfunction

        function void record_item(ray_item_t it);
            longint px, py, rx, ry, bx, by, bt, count;
            longint sxv, syv, qx, qy, d, tn, un, tq;
            bit found;
            hit_item_t res;
            if (it.cmd == CMD_LOAD)
            begin
                walls[it.wall_index] = it;
                return;
            end
            px = it.start_x;
            py = it.start_y;
            rx = longint'(it.end_x) - px;
            ry = longint'(it.end_y) - py;
            bx = it.end_x;
            by = it.end_y;
            bt = 0;
            found = 0;
            count = (wall_count > MAX_WALLS_DEF) ? MAX_WALLS_DEF : wall_count;
            for (int i = 0; i < count; i++)
            begin
                sxv = longint'(walls[i].end_x) - longint'(walls[i].start_x);
                syv = longint'(walls[i].end_y) - longint'(walls[i].start_y);
                qx = longint'(walls[i].start_x) - px;
                qy = longint'(walls[i].start_y) - py;
                d = rx * syv - ry * sxv;
                tn = qx * syv - qy * sxv;
                un = qx * ry - qy * rx;
                if (d == 0)
                    continue;
                if (d < 0)
                begin
                    d = -d;
                    tn = -tn;
                    un = -un;
                end
                if (tn < 0 || tn > d || un < 0 || un > d)
                    continue;
                tq = t_quantize(tn, d);
                if (!found || tq < bt)
                begin
                    found = 1;
                    bt = tq;
                    bx = px + ((rx * tq) >>> T_FRAC_BITS_DEF);
                    by = py + ((ry * tq) >>> T_FRAC_BITS_DEF);
                end
            end
            res.hit = found;
            res.hit_x = bx[COORD_W-1:0];
            res.hit_y = by[COORD_W-1:0];
            res.hit_t = found ? bt[T_FRAC_BITS_DEF:0] : '0;
            expected_hits.insert(expected_hits.size(), res);
        endfunction

        task check_hit(hit_item_t got);
            hit_item_t exp;
            if (expected_hits.size() == 0)
            begin
                report($sformatf("unexpected result hit=%0d x=%0d y=%0d t=%0d",
                    got.hit, got.hit_x, got.hit_y, got.hit_t));
                return;
            end
            exp = expected_hits.pop_front();
            if (got.hit !== exp.hit)
                report($sformatf("hit got %0d exp %0d", got.hit, exp.hit));
            if (got.hit_x !== exp.hit_x)
                report($sformatf("hit_x got %0d exp %0d", got.hit_x, exp.hit_x));
            if (got.hit_y !== exp.hit_y)
                report($sformatf("hit_y got %0d exp %0d", got.hit_y, exp.hit_y));
            if (got.hit_t !== exp.hit_t)
                report($sformatf("hit_t got %0d exp %0d", got.hit_t, exp.hit_t));
        endtask
    endclass

endpackage

// ===== dv/ray_segment_closest_hit_test.sv =====
// Top of the ray segment closest hit testbench: clock, reset, stimulus, checking.
// Depends on rsch_pkg, rsch_if, ray_segment_closest_hit_tb_pkg and the block.
`timescale 1ns / 1ps
module ray_segment_closest_hit_test;
    import rsch_pkg::*;
    import ray_segment_closest_hit_tb_pkg::*;

    localparam longint CYCLE_LIMIT = 10000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CNT_W-1:0] cfg_data = '0;

    rsch_if #(.PAYLOAD_T(ray_item_t)) in_ch (clk);
    rsch_if #(.PAYLOAD_T(hit_item_t)) out_ch (clk);

    ray_segment_closest_hit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (in_ch.sink),
        .out_ch   (out_ch.source)
    );

    hit_scoreboard sb = new();
    int     tx_idle_pct = 0;
    int     rx_idle_pct = 0;
    bit     rx_hold = 1'b0;
    event   rx_hold_ev;
    longint cycles = 0;

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // long receiver stall, counted here
    initial
    begin
        forever
        begin
            @(rx_hold_ev);
            rx_hold <= 1'b1;
            repeat (400) @(posedge clk);
            rx_hold <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_hit(out_ch.data);
        if (rx_hold)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task send_item(ray_item_t it);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.record_item(it);
    endtask

    task wait_idle();
        in_ch.valid <= 1'b0;
        while (sb.expected_hits.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task write_wall_count(int value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_data <= value[CNT_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.wall_count = value;
        @(posedge clk);
    endtask

    function automatic ray_item_t make_item(logic cmd, int idx,
        int sx, int sy, int ex, int ey);
        ray_item_t it;
        it.cmd = cmd;
        it.wall_index = idx[IDX_W-1:0];
        it.start_x = sx[COORD_W-1:0];
        it.start_y = sy[COORD_W-1:0];
        it.end_x = ex[COORD_W-1:0];
        it.end_y = ey[COORD_W-1:0];
        return it;
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        if ($urandom_range(99) < 25)
            return COORD_W'($urandom());
        return COORD_W'($urandom_range(4095) - 2048);
    endfunction

    function automatic ray_item_t rand_item(bit load);
        ray_item_t it;
        it.cmd = load ? CMD_LOAD : CMD_CAST;
        it.wall_index = IDX_W'($urandom());
        it.start_x = rand_coord();
        it.start_y = rand_coord();
        it.end_x = rand_coord();
        it.end_y = rand_coord();
        return it;
    endfunction

    task run_phase(int items, bit hold_rx, bit pause_tx);
        int n;
        int seg;
        int r;
        n = 0;
        while (n < items)
        begin
            r = $urandom_range(99);
            if (r < 8)
                write_wall_count(0);
            else if (r < 16)
                write_wall_count($urandom_range(127, 64));
            else
                write_wall_count($urandom_range(8, 1));
            if (hold_rx && n == 0)
                -> rx_hold_ev;
            seg = $urandom_range(40, 20);
            for (int i = 0; i < seg && n < items; i++, n++)
            begin
                send_item(rand_item($urandom_range(99) < 45));
                if (pause_tx && n == items / 2)
                    wait_idle();
            end
        end
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no walls: the ray end comes back
        write_wall_count(0);
        send_item(make_item(CMD_CAST, 0, 0, 0, 320, 0));
        send_item(make_item(CMD_LOAD, 0, 160, -160, 160, 160));
        send_item(make_item(CMD_LOAD, 1, 0, 0, 640, 0));
        send_item(make_item(CMD_LOAD, 2, 80, -160, 80, 160));
        send_item(make_item(CMD_LOAD, 3, 80, 160, 80, -160));
        send_item(make_item(CMD_LOAD, 4, 320, -16, 320, 16));
        send_item(make_item(CMD_LOAD, 5, -8388608, -8388608, 8388607, 8388607));
        send_item(make_item(CMD_LOAD, 6, 8388607, -8388608, -8388608, 8388607));
        write_wall_count(7);
        send_item(make_item(CMD_CAST, 0, 0, 0, 320, 0));
        send_item(make_item(CMD_CAST, 63, -640, 100, -320, 100));
        send_item(make_item(CMD_CAST, 0, 80, 0, 400, 0));
        send_item(make_item(CMD_CAST, 0, 400, 5, 320, 5));
        send_item(make_item(CMD_CAST, 0, 320, 0, 0, 0));
        send_item(make_item(CMD_CAST, 0, -8388608, 8388607, 8388607, -8388608));
        send_item(make_item(CMD_CAST, 0, 8388607, 8388607, -8388608, -8388608));
        send_item(make_item(CMD_CAST, 0, -7, -3, -7, -3));
        write_wall_count(1);
        send_item(make_item(CMD_CAST, 0, 0, 0, 320, 0));

        for (int i = 0; i < MAX_WALLS_DEF; i++)
            send_item(rand_item(1));
        write_wall_count(127);
        send_item(rand_item(0));
        send_item(rand_item(0));
        write_wall_count(64);
        send_item(rand_item(0));

        tx_idle_pct = 28;
        rx_idle_pct = 59;
        run_phase(170, 1, 0);
        tx_idle_pct = 59;
        rx_idle_pct = 28;
        run_phase(170, 0, 1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(170, 0, 0);

        wait_idle();
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
